// ----- src/vfd_grid_scan_refresh_top_defines.svh -----
// ----------------------------------------------------------------------------
// VFD grid scan refresh assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef VFD_GRID_SCAN_REFRESH_TOP_DEFINES_SVH
`define VFD_GRID_SCAN_REFRESH_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define VGSR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgsr same-cycle property failed");

// next-cycle implication, sampled on clk, off during reset
`define VGSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgsr next-cycle property failed");

`endif

// ----- src/vgsr_pkg.sv -----
// ----------------------------------------------------------------------------
// VGSR package
// Types, constants and byte formatting shared by the grid scanner modules.
// ----------------------------------------------------------------------------
package vgsr_pkg;

    localparam int NUM_GRIDS     = 18;
    localparam int GRID_W        = 5;
    localparam int WORD_W        = 40;
    localparam int DIV_W         = 16;
    localparam int UNDERLINE_BIT = 35;
    localparam int QUEUE_DEPTH   = 2;
    localparam logic [15:0] DIV_RESET = 16'd250;
    localparam logic [4:0]  LAST_GRID = 5'd17;
    localparam logic [2:0]  LAST_BYTE = 3'd6;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_UNDERLINE = 2'd2,
        OP_TOGGLE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        MODE_OFF  = 3'b001,
        MODE_ON   = 3'b010,
        MODE_PEND = 3'b100
    } mode_t;

    typedef struct packed {
        logic                blank;
        logic [GRID_W-1:0]   grid;
        logic [WORD_W-1:0]   word;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] frame_byte(frame_t f, logic [2:0] k);
        logic [7:0] sel5;
        logic [7:0] sel6;
        logic [7:0] sel7;
        logic [7:0] b;
        sel5 = 8'h00;
        sel6 = 8'h00;
        sel7 = 8'h00;
        case (f.grid) inside
            [5'd0:5'd3]:  sel5 = 8'h10 << f.grid[1:0];
            [5'd4:5'd9]:  sel7 = 8'h20 >> (f.grid - 5'd4);
            default:      sel6 = 8'h80 >> (f.grid - 5'd10);
        endcase
        case (k)
            3'd0:    b = f.word[7:0];
            3'd1:    b = f.word[15:8];
            3'd2:    b = f.word[23:16];
            3'd3:    b = f.word[31:24];
            3'd4:    b = f.word[39:32] | sel5;
            3'd5:    b = sel6;
            default: b = sel7;
        endcase
        if (f.blank)
        begin
            b = 8'h00;
        end
        return ~b;
    endfunction

endpackage

// ----- src/vgsr_front.sv -----
// ----------------------------------------------------------------------------
// VGSR front end
// Accepts ops, holds segment memory, divider, scan state; queues frames.
// ----------------------------------------------------------------------------
module vgsr_front
    import vgsr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [GRID_W-1:0]   grid_index,
    input  logic [WORD_W-1:0]   segment_word,
    input  logic                underline_on,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DIV_W-1:0]    cfg_data,
    input  q_stat_t             q_stat,
    output logic                q_push,
    output frame_t              q_frame
);

    logic [WORD_W-1:0]    seg_mem_reg [NUM_GRIDS];
    logic [NUM_GRIDS-1:0] seg_valid_reg;
    logic [DIV_W-1:0]     divider_reg;
    logic [DIV_W-1:0]     count_reg, count_next;
    logic [GRID_W-1:0]    grid_reg, grid_next;
    logic                 underline_reg, underline_next;
    mode_t                mode_reg, mode_next;
    logic                 accept;
    logic                 mem_write;
    logic [GRID_W-1:0]    adv_grid;
    logic [WORD_W-1:0]    rd_word;

    assign in_stall  = q_stat.full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign adv_grid  = (grid_reg >= LAST_GRID) ? '0 : grid_reg + 5'd1;

    always_comb
    begin
        rd_word = seg_valid_reg[adv_grid] ? seg_mem_reg[adv_grid] : '0;
        if (adv_grid >= 5'd4)
        begin
            rd_word[UNDERLINE_BIT] = underline_reg;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        grid_next      = grid_reg;
        underline_next = underline_reg;
        mode_next      = mode_reg;
        mem_write      = 1'b0;
        q_push         = 1'b0;
        q_frame.blank  = 1'b0;
        q_frame.grid   = adv_grid;
        q_frame.word   = rd_word;
        if (accept)
        begin
            case (op_t'(op))
                OP_TICK:
                begin
                    if (mode_reg == MODE_ON)
                    begin
                        if (count_reg >= divider_reg)
                        begin
                            count_next = '0;
                            grid_next  = adv_grid;
                            q_push     = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 16'd1;
                        end
                    end
                    else if (mode_reg == MODE_PEND)
                    begin
                        mode_next     = MODE_OFF;
                        q_push        = 1'b1;
                        q_frame.blank = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    mem_write = (grid_index < 5'(NUM_GRIDS));
                end
                OP_UNDERLINE:
                begin
                    underline_next = underline_on;
                end
                OP_TOGGLE:
                begin
                    mode_next = (mode_reg == MODE_ON) ? MODE_PEND : MODE_ON;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_write)
        begin
            seg_mem_reg[grid_index] <= segment_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= '0;
            divider_reg   <= DIV_RESET;
            count_reg     <= '0;
            grid_reg      <= '0;
            underline_reg <= 1'b0;
            mode_reg      <= MODE_ON;
        end
        else
        begin
            if (mem_write)
            begin
                seg_valid_reg[grid_index] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                divider_reg <= cfg_data;
            end
            count_reg     <= count_next;
            grid_reg      <= grid_next;
            underline_reg <= underline_next;
            mode_reg      <= mode_next;
        end
    end

endmodule

// ----- src/vgsr_fifo.sv -----
// ----------------------------------------------------------------------------
// VGSR frame queue
// Short queue of frame descriptors between front and back end.
// ----------------------------------------------------------------------------
module vgsr_fifo
    import vgsr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  frame_t  push_frame,
    input  logic    pop,
    output frame_t  head,
    output q_stat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             data_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/vgsr_back.sv -----
// ----------------------------------------------------------------------------
// VGSR back end
// Serializes one queued frame into seven driver bytes behind an output register.
// ----------------------------------------------------------------------------
module vgsr_back
    import vgsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  frame_t     head,
    input  q_stat_t    q_stat,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] shift_byte,
    output logic       last_of_frame
);

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;

    assign load          = !q_stat.empty && (!valid_reg || !out_stall);
    assign q_pop         = load && (idx_reg == LAST_BYTE);
    assign out_valid     = valid_reg;
    assign shift_byte    = byte_reg;
    assign last_of_frame = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= frame_byte(head, idx_reg);
            last_reg <= (idx_reg == LAST_BYTE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= (idx_reg == LAST_BYTE) ? '0 : idx_reg + 3'd1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- src/vfd_grid_scan_refresh_top.sv -----
// ----------------------------------------------------------------------------
// VFD grid scan refresh
// Multiplexed 18-grid VFD refresh: tick divider, grid scan, 7-byte frames.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------
//  in      | in  | in_valid / in_stall    | op, grid_index, segment_word, underline_on
//  out     | out | out_valid / out_stall  | shift_byte, last_of_frame
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_data (refresh_divider)
//
//  One op accepted per cycle while in_stall is low; a frame leaves as seven bytes,
//  one per cycle while out_stall is low, from the back end's byte counter and output register.
//  in_stall rises only while the frame queue (QDEPTH frames, QUEUE_DEPTH by default) is full.
//  cfg_ready is always high. Reset is asynchronous, memory reads zero until written.
// ----------------------------------------------------------------------------
module vfd_grid_scan_refresh_top
    import vgsr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [GRID_W-1:0]   grid_index,
    input  logic [WORD_W-1:0]   segment_word,
    input  logic                underline_on,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DIV_W-1:0]    cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          shift_byte,
    output logic                last_of_frame
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    frame_t  q_frame;
    frame_t  q_head;

    vgsr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .grid_index   (grid_index),
        .segment_word (segment_word),
        .underline_on (underline_on),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_frame      (q_frame)
    );

    vgsr_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_frame (q_frame),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    vgsr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shift_byte    (shift_byte),
        .last_of_frame (last_of_frame)
    );

endmodule

// ----- src/vgsr_checker.sv -----
// ----------------------------------------------------------------------------
// VGSR port checker
// Frame framing and select-byte properties seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "vfd_grid_scan_refresh_top_defines.svh"

module vgsr_checker
    import vgsr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [7:0]          shift_byte,
    input  logic                last_of_frame
);

    logic [2:0] byte_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            byte_cnt_reg <= last_of_frame ? '0 : byte_cnt_reg + 3'd1;
        end
    end

    `VGSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(shift_byte) && $stable(last_of_frame))
    `VGSR_ASSERT_SAME(a_last_seventh, out_valid, last_of_frame == (byte_cnt_reg == LAST_BYTE))
    `VGSR_ASSERT_SAME(a_select_one_hot, out_valid && (byte_cnt_reg >= 3'd5), $countones(~shift_byte) <= 1)

endmodule

bind vfd_grid_scan_refresh_top vgsr_checker u_vgsr_checker (.*);

// ----- verif/vfd_grid_scan_refresh_checker.sv -----
// ----------------------------------------------------------------------------
// VFD grid scan refresh checker
// Watches the op, config and byte channels, keeps its own copy of the scanner
// state, predicts the driver-chain bytes of each frame and compares every
// output transaction against the oldest predicted byte.
// ----------------------------------------------------------------------------
module vfd_grid_scan_refresh_checker
    import vgsr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          op,
    input  logic [GRID_W-1:0]   grid_index,
    input  logic [WORD_W-1:0]   segment_word,
    input  logic                underline_on,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [DIV_W-1:0]    cfg_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [7:0]          shift_byte,
    input  logic                last_of_frame,
    output int                  fail_count,
    output int                  pending_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } chain_byte_t;

    chain_byte_t         chain_bytes_q[$];
    logic [WORD_W-1:0]   grid_mem [NUM_GRIDS];
    logic [GRID_W-1:0]   active_grid;
    logic [DIV_W-1:0]    tick_cnt;
    logic [DIV_W-1:0]    divider;
    logic                underline_flag;
    mode_t               mode;
    int                  errors = 0;
    int                  queued = 0;

    assign fail_count    = errors;
    assign pending_bytes = queued;

    task automatic queue_frame(input logic blank);
        logic [7:0]        sel5;
        logic [7:0]        sel6;
        logic [7:0]        sel7;
        logic [WORD_W-1:0] w;
        int                k;
        if (blank)
        begin
            for (k = 0; k < 7; k++)
                chain_bytes_q.push_back('{value: 8'hFF, last: (k == 6)});
            return;
        end
        sel5 = 8'h00;
        sel6 = 8'h00;
        sel7 = 8'h00;
        if (active_grid < 5'd4)
            sel5 = 8'h10 << active_grid;
        else if (active_grid < 5'd10)
            sel7 = 8'h20 >> (active_grid - 5'd4);
        else
            sel6 = 8'h80 >> (active_grid - 5'd10);
        if (active_grid >= 5'd4)
            grid_mem[active_grid][UNDERLINE_BIT] = underline_flag;
        w = grid_mem[active_grid];
        for (k = 0; k < 4; k++)
            chain_bytes_q.push_back('{value: ~w[8*k +: 8], last: 1'b0});
        chain_bytes_q.push_back('{value: ~(w[39:32] | sel5), last: 1'b0});
        chain_bytes_q.push_back('{value: ~sel6, last: 1'b0});
        chain_bytes_q.push_back('{value: ~sel7, last: 1'b1});
    endtask

    task automatic advance_scanner(input op_t o, input logic [GRID_W-1:0] idx,
                                   input logic [WORD_W-1:0] word, input logic ul);
        case (o)
            OP_TICK:
            begin
                if (mode == MODE_ON)
                begin
                    if (tick_cnt >= divider)
                    begin
                        tick_cnt = '0;
                        active_grid = (active_grid >= LAST_GRID) ? '0 : active_grid + 5'd1;
                        queue_frame(1'b0);
                    end
                    else
                    begin
                        tick_cnt = tick_cnt + 16'd1;
                    end
                end
                else if (mode == MODE_PEND)
                begin
                    mode = MODE_OFF;
                    queue_frame(1'b1);
                end
            end
            OP_WRITE:
            begin
                if (idx < NUM_GRIDS)
                    grid_mem[idx] = word;
            end
            OP_UNDERLINE:
            begin
                underline_flag = ul;
            end
            default:
            begin
                mode = (mode == MODE_ON) ? MODE_PEND : MODE_ON;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        chain_byte_t oldest;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GRIDS; i++)
                grid_mem[i] = '0;
            active_grid    = '0;
            tick_cnt       = '0;
            divider        = DIV_RESET;
            underline_flag = 1'b0;
            mode           = MODE_ON;
            chain_bytes_q.delete();
            queued         = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (chain_bytes_q.size() == 0)
                begin
                    $error("shift_byte: unexpected transaction, actual %h", shift_byte);
                    errors++;
                end
                else
                begin
                    oldest = chain_bytes_q.pop_front();
                    if (shift_byte !== oldest.value)
                    begin
                        $error("shift_byte: expected %h, actual %h", oldest.value, shift_byte);
                        errors++;
                    end
                    if (last_of_frame !== oldest.last)
                    begin
                        $error("last_of_frame: expected %b, actual %b",
                               oldest.last, last_of_frame);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                divider = cfg_data;
            if (in_valid && !in_stall)
                advance_scanner(op_t'(op), grid_index, segment_word, underline_on);
            queued = chain_bytes_q.size();
        end
    end

endmodule

// ----- verif/tb_vfd_grid_scan_refresh_top.sv -----
// ----------------------------------------------------------------------------
// VFD grid scan refresh testbench
// Drives directed and random op sequences in bursts under several refresh
// divider settings, stalls the byte channel on shifting patterns and leaves
// frame prediction and byte checking to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_vfd_grid_scan_refresh_top;
    import vgsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 20;
    localparam int PHASE_ITEMS  = 36;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          op;
    logic [GRID_W-1:0]   grid_index;
    logic [WORD_W-1:0]   segment_word;
    logic                underline_on;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [DIV_W-1:0]    cfg_data;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          shift_byte;
    logic                last_of_frame;
    int                  fail_count;
    int                  pending_bytes;
    int                  burst_left = 0;
    int                  stall_left = 0;
    int                  stall_style = 0;
    int                  stall_phase = 0;
    int                  cycle_count = 0;

    vfd_grid_scan_refresh_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .grid_index    (grid_index),
        .segment_word  (segment_word),
        .underline_on  (underline_on),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shift_byte    (shift_byte),
        .last_of_frame (last_of_frame)
    );

    vfd_grid_scan_refresh_checker frame_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .grid_index    (grid_index),
        .segment_word  (segment_word),
        .underline_on  (underline_on),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shift_byte    (shift_byte),
        .last_of_frame (last_of_frame),
        .fail_count    (fail_count),
        .pending_bytes (pending_bytes)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(20, 150);
            end
            stall_left--;
            stall_phase++;
            case (stall_style)
                0:       out_stall = 1'b0;
                1:       out_stall = 1'($urandom_range(0, 1));
                2:       out_stall = ($urandom_range(0, 3) == 0);
                default: out_stall = ((stall_phase % 9) < 6);
            endcase
        end
    end

    task automatic send_op(input op_t o, input logic [GRID_W-1:0] idx,
                           input logic [WORD_W-1:0] word, input logic ul);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid     = 1'b1;
        op           = o;
        grid_index   = idx;
        segment_word = word;
        underline_on = ul;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_bytes != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_divider(input logic [DIV_W-1:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic op_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return OP_TICK;
        else if (r < 85)
            return OP_WRITE;
        else if (r < 93)
            return OP_UNDERLINE;
        else
            return OP_TOGGLE;
    endfunction

    function automatic logic [GRID_W-1:0] pick_grid();
        if ($urandom_range(0, 7) == 0)
            return GRID_W'($urandom_range(NUM_GRIDS, 31));
        return GRID_W'($urandom_range(0, NUM_GRIDS - 1));
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {8'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic send_random();
        send_op(pick_op(), pick_grid(), pick_word(), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [DIV_W-1:0] phase_div [6];
        phase_div    = '{16'd0, 16'd1, 16'd3, 16'd65535, 16'd0, 16'd5};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_TICK;
        grid_index   = '0;
        segment_word = '0;
        underline_on = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        out_stall    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_divider(16'd0);
        send_op(OP_WRITE, 5'd0, '1, 1'b0);
        send_op(OP_WRITE, 5'd1, '0, 1'b1);
        send_op(OP_WRITE, 5'd4, '0, 1'b0);
        send_op(OP_WRITE, 5'd5, '1, 1'b1);
        send_op(OP_WRITE, 5'd18, pick_word(), 1'b0);
        send_op(OP_WRITE, 5'd31, '1, 1'b1);
        send_op(OP_WRITE, 5'd17, 40'h5A_C3_3C_96_69, 1'b0);
        send_op(OP_UNDERLINE, 5'd0, '0, 1'b1);
        repeat (5) send_op(OP_TICK, 5'd0, '0, 1'b0);
        send_op(OP_UNDERLINE, 5'd0, '1, 1'b0);
        send_op(OP_TICK, 5'd31, '1, 1'b1);
        send_op(OP_TOGGLE, 5'd0, '0, 1'b0);
        send_op(OP_TICK, 5'd0, '0, 1'b0);
        send_op(OP_TICK, 5'd0, '0, 1'b0);
        send_op(OP_TOGGLE, 5'd0, '0, 1'b0);
        send_op(OP_TICK, 5'd0, '0, 1'b0);
        send_op(OP_TOGGLE, 5'd0, '0, 1'b0);
        send_op(OP_TOGGLE, 5'd0, '0, 1'b0);
        send_op(OP_TICK, 5'd0, '0, 1'b0);

        // Hold ticks under the largest divider, then drop it below the count
        set_divider(16'd65535);
        repeat (4) send_op(OP_TICK, 5'd0, '0, 1'b0);
        set_divider(16'd2);
        repeat (3) send_op(OP_TICK, 5'd0, '0, 1'b0);

        foreach (phase_div[p])
        begin
            set_divider(phase_div[p]);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
                send_random();
            end
        end

        in_valid = 1'b0;
        while (pending_bytes != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0 && pending_bytes == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
